[design/bcfla_pkg.sv]
// ----------------------------------------------------------------------------
// bcfla_pkg
// Shared types and constants of the block-carving free-list allocator.
// ----------------------------------------------------------------------------
package bcfla_pkg;

  // Slot geometry. A slot address is {block, element}.
  localparam int unsigned BLK_W         = 6;
  localparam int unsigned ELEM_W        = 6;
  localparam int unsigned ADDR_W        = BLK_W + ELEM_W;
  localparam int unsigned MAX_BLOCKS    = 1 << BLK_W;
  localparam int unsigned MAX_PER_BLOCK = 1 << ELEM_W;
  localparam int unsigned CFG_W         = 7;

  typedef logic [BLK_W-1:0]         blk_t;
  typedef logic [ELEM_W-1:0]        elem_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [MAX_PER_BLOCK-1:0] map_row_t;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PER_BLOCK   = 2'd0,
    CFG_BLOCK_LIMIT = 2'd1,
    CFG_CHECK_FREES = 2'd2
  } cfg_idx_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_MEM    = 2'd1,
    STATUS_ALRDY_FREE = 2'd2,
    STATUS_NOT_OWNED = 2'd3
  } status_t;

  // Access to the link memory.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    addr_t wr_data;
  } link_req_t;

  // Access to the allocation bitmap, one row per block.
  typedef struct packed {
    logic     rd_en;
    blk_t     rd_row;
    logic     wr_en;
    blk_t     wr_row;
    map_row_t wr_data;
  } map_req_t;

endpackage

[design/bcfla_link_ram.sv]
// ----------------------------------------------------------------------------
// bcfla_link_ram
// Link memory of the free stack: one next-slot address per slot.
// ----------------------------------------------------------------------------
module bcfla_link_ram (
  input  logic                clk,
  input  bcfla_pkg::link_req_t req,
  output bcfla_pkg::addr_t    rd_data
);

  localparam int unsigned DEPTH = 1 << bcfla_pkg::ADDR_W;

  bcfla_pkg::addr_t mem [DEPTH];
  bcfla_pkg::addr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/bcfla_map_ram.sv]
// ----------------------------------------------------------------------------
// bcfla_map_ram
// Allocation bitmap, one row of slot bits per block, with a clearing
// sweep over all rows after reset.
// ----------------------------------------------------------------------------
module bcfla_map_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  bcfla_pkg::map_req_t req,
  output bcfla_pkg::map_row_t rd_data,
  output logic                clr_busy
);

  localparam int unsigned ROWS = bcfla_pkg::MAX_BLOCKS;

  bcfla_pkg::map_row_t mem [ROWS];
  bcfla_pkg::map_row_t rd_data_r;

  // The top bit of the sweep counter marks the sweep as finished.
  logic [bcfla_pkg::BLK_W:0] clr_cnt_r;
  logic [bcfla_pkg::BLK_W:0] clr_cnt_nxt;

  assign clr_busy    = ~clr_cnt_r[bcfla_pkg::BLK_W];
  assign clr_cnt_nxt = clr_busy ? clr_cnt_r + 1'b1 : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_cnt_r[bcfla_pkg::BLK_W-1:0]] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_row];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/block_carving_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// block_carving_free_list_allocator
// Slot allocator with a LIFO free stack and block carving.
// ----------------------------------------------------------------------------
// For each item the accept cycle issues reads of the link memory and the
// bitmap row; the execute state then modifies the bitmap row, writes the
// link memory for a freed slot and loads the result into the output
// register. That read-modify-write sets the rate: no new item is taken
// until the last leaves the execute state, which an untaken result holds.
// After reset the allocation bitmap is cleared one block row a cycle,
// while no item is accepted; configuration writes are taken throughout.
module block_carving_free_list_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bcfla_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [bcfla_pkg::BLK_W-1:0]  in_blk,
  input  logic [bcfla_pkg::ELEM_W-1:0] in_elem,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bcfla_pkg::BLK_W-1:0]  out_got_block,
  output logic [bcfla_pkg::ELEM_W-1:0] out_got_elem,
  output logic [1:0]                   out_status
);

  localparam int unsigned BW = bcfla_pkg::BLK_W;
  localparam int unsigned EW = bcfla_pkg::ELEM_W;
  localparam int unsigned CW = bcfla_pkg::CFG_W;
  localparam logic [CW-1:0] PB_MIN  = CW'(2);
  localparam logic [CW-1:0] PB_MAX  = CW'(bcfla_pkg::MAX_PER_BLOCK);
  localparam logic [CW-1:0] LIM_MAX = CW'(bcfla_pkg::MAX_BLOCKS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef enum logic [1:0] {
    AL_POP  = 2'd0,
    AL_CONT = 2'd1,
    AL_NEW  = 2'd2,
    AL_FAIL = 2'd3
  } amode_t;

  // Configuration.
  logic [CW-1:0] per_block_r;
  logic [CW-1:0] block_limit_r;
  logic          check_frees_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_block_r   <= PB_MAX;
      block_limit_r <= LIM_MAX;
      check_frees_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (bcfla_pkg::cfg_idx_t'(cfg_index))
        bcfla_pkg::CFG_PER_BLOCK:   per_block_r   <= cfg_wdata;
        bcfla_pkg::CFG_BLOCK_LIMIT: block_limit_r <= cfg_wdata;
        bcfla_pkg::CFG_CHECK_FREES: check_frees_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] eff_pb;
  logic [CW-1:0] eff_lim;

  assign eff_pb  = (per_block_r < PB_MIN) ? PB_MIN :
                   (per_block_r > PB_MAX) ? PB_MAX : per_block_r;
  assign eff_lim = (block_limit_r > LIM_MAX) ? LIM_MAX : block_limit_r;

  // Allocator state.
  state_t            state_r, state_nxt;
  bcfla_pkg::addr_t  stack_head_r, stack_head_nxt;
  logic              stack_empty_r, stack_empty_nxt;
  logic [EW-1:0]     cursor_r, cursor_nxt;
  logic [CW-1:0]     carved_r, carved_nxt;

  // Item held between the accept cycle and the execute state.
  logic              kind_r;
  amode_t            amode_r;
  bcfla_pkg::addr_t  addr_r;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [BW-1:0]     got_block_r, got_block_nxt;
  logic [EW-1:0]     got_elem_r, got_elem_nxt;
  bcfla_pkg::status_t status_r, status_nxt;

  // Memories.
  bcfla_pkg::link_req_t link_req;
  bcfla_pkg::addr_t     link_rd;
  bcfla_pkg::map_req_t  map_req;
  bcfla_pkg::map_row_t  map_rd;
  logic                 clr_busy;

  bcfla_link_ram u_link (
    .clk     (clk),
    .req     (link_req),
    .rd_data (link_rd)
  );

  bcfla_map_ram u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (map_req),
    .rd_data  (map_rd),
    .clr_busy (clr_busy)
  );

  logic accept;
  logic finish;

  assign in_ready = (state_r == ST_IDLE) && !clr_busy;
  assign accept   = in_valid && in_ready;
  assign finish   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  // Address and allocation path, decided from the state at accept.
  amode_t           acc_mode;
  bcfla_pkg::addr_t acc_addr;
  logic [CW-1:0]    pb_top;
  logic [BW-1:0]    carved_lo;

  assign pb_top    = eff_pb - 1'b1;
  assign carved_lo = carved_r[BW-1:0];

  always_comb begin
    acc_mode = AL_POP;
    acc_addr = '0;
    if (in_kind == bcfla_pkg::KIND_FREE) begin
      acc_addr = {in_blk, in_elem};
    end else if (!stack_empty_r) begin
      acc_mode = AL_POP;
      acc_addr = stack_head_r;
    end else if (cursor_r != '0) begin
      acc_mode = AL_CONT;
      acc_addr = {carved_lo - 1'b1, cursor_r};
    end else if (carved_r >= eff_lim) begin
      acc_mode = AL_FAIL;
    end else begin
      acc_mode = AL_NEW;
      acc_addr = {carved_lo, pb_top[EW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      amode_r <= acc_mode;
      addr_r  <= acc_addr;
    end
  end

  // Read-modify-write cycle.
  logic [BW-1:0]       op_blk;
  logic [EW-1:0]       op_elem;
  logic                cur_bit;
  bcfla_pkg::map_row_t bit_mask;
  logic                do_push;
  logic                do_alloc;

  assign op_blk   = addr_r[bcfla_pkg::ADDR_W-1:EW];
  assign op_elem  = addr_r[EW-1:0];
  assign bit_mask = bcfla_pkg::map_row_t'(1) << op_elem;
  assign cur_bit  = map_rd[op_elem];

  always_comb begin
    state_nxt       = state_r;
    stack_head_nxt  = stack_head_r;
    stack_empty_nxt = stack_empty_r;
    cursor_nxt      = cursor_r;
    carved_nxt      = carved_r;
    got_block_nxt   = got_block_r;
    got_elem_nxt    = got_elem_r;
    status_nxt      = status_r;
    out_valid_nxt   = out_ready ? 1'b0 : out_valid_r;
    do_push         = 1'b0;
    do_alloc        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          got_block_nxt = '0;
          got_elem_nxt  = '0;
          status_nxt    = bcfla_pkg::STATUS_OK;
          if (kind_r == bcfla_pkg::KIND_ALLOC) begin
            case (amode_r)
              AL_FAIL: begin
                status_nxt = bcfla_pkg::STATUS_NO_MEM;
              end
              AL_POP: begin
                do_alloc        = 1'b1;
                stack_head_nxt  = link_rd;
                stack_empty_nxt = (link_rd == '0);
              end
              AL_NEW: begin
                do_alloc   = 1'b1;
                carved_nxt = carved_r + 1'b1;
                cursor_nxt = op_elem - 1'b1;
              end
              default: begin
                do_alloc   = 1'b1;
                cursor_nxt = cursor_r - 1'b1;
              end
            endcase
            if (do_alloc) begin
              got_block_nxt = op_blk;
              got_elem_nxt  = op_elem;
            end
          end else if (check_frees_r) begin
            if (cur_bit) begin
              do_push = 1'b1;
            end else if (({1'b0, op_blk} < carved_r) && (op_elem != '0) &&
                         ({1'b0, op_elem} < eff_pb)) begin
              status_nxt = bcfla_pkg::STATUS_ALRDY_FREE;
            end else begin
              status_nxt = bcfla_pkg::STATUS_NOT_OWNED;
            end
          end else begin
            do_push = (op_elem != '0);
          end
          if (do_push) begin
            stack_head_nxt  = addr_r;
            stack_empty_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    link_req.rd_en   = accept;
    link_req.rd_addr = acc_addr;
    link_req.wr_en   = do_push;
    link_req.wr_addr = addr_r;
    link_req.wr_data = stack_empty_r ? '0 : stack_head_r;

    map_req.rd_en    = accept;
    map_req.rd_row   = acc_addr[bcfla_pkg::ADDR_W-1:EW];
    map_req.wr_en    = do_push || do_alloc;
    map_req.wr_row   = op_blk;
    map_req.wr_data  = do_alloc ? (map_rd | bit_mask) : (map_rd & ~bit_mask);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      stack_head_r  <= '0;
      stack_empty_r <= 1'b1;
      cursor_r      <= '0;
      carved_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stack_head_r  <= stack_head_nxt;
      stack_empty_r <= stack_empty_nxt;
      cursor_r      <= cursor_nxt;
      carved_r      <= carved_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    got_block_r <= got_block_nxt;
    got_elem_r  <= got_elem_nxt;
    status_r    <= status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_got_block = got_block_r;
  assign out_got_elem  = got_elem_r;
  assign out_status    = status_r;

endmodule
